>>> sv/sbbc_pkg.sv
// sbbc_pkg: shared types and constants for the speech band biquad cascade
// no dependencies; used by the interfaces, controller, datapath and top level
package sbbc_pkg;

    localparam int SAMPLE_W  = 16;
    localparam int COEF_W    = 32;
    localparam int CFG_IDX_W = 3;
    localparam int NCH_W     = 2;
    localparam int ROW_BITS  = 4 * COEF_W;
    localparam int Q_FRAC    = 28;
    localparam int IN_SHIFT  = 13;
    localparam int TERM_W    = 3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_HP_B0  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HP_A1  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HP_A2  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LP_B0  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LP_A1  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_LP_A2  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_CH = 3'd6;

    // product terms of one section, in issue order
    localparam logic [TERM_W-1:0] TERM_X    = 3'd0;
    localparam logic [TERM_W-1:0] TERM_X1   = 3'd1;
    localparam logic [TERM_W-1:0] TERM_X2   = 3'd2;
    localparam logic [TERM_W-1:0] TERM_Y1   = 3'd3;
    localparam logic [TERM_W-1:0] TERM_Y2   = 3'd4;
    localparam logic [TERM_W-1:0] TERM_NONE = 3'd5;

    // 0.9999 in q4.28 and the output scale
    localparam logic [Q_FRAC-1:0] CLAMP_Q   = 28'd268408612;
    localparam logic [14:0]       OUT_SCALE = 15'd32767;

    typedef struct packed {
        logic                start;
        logic                rd;
        logic                mul;
        logic [TERM_W-1:0]   term;
        logic                acc;
        logic                wb;
        logic                is_lp;
        logic                conv;
        logic                load_out;
    } t_cmd;

    typedef struct packed {
        logic out_free;
    } t_stat;

endpackage

>>> sv/sbbc_ifs.sv
// sbbc channel interfaces: sample input, result output, register write
// depends on sbbc_pkg for field widths
interface sbbc_in_if;
    logic                                valid;
    logic                                ready;
    logic signed [sbbc_pkg::SAMPLE_W-1:0] sample_in;
    logic                                clear_history;

    modport source (output valid, output sample_in, output clear_history, input ready);
    modport sink   (input valid, input sample_in, input clear_history, output ready);
endinterface

interface sbbc_out_if;
    logic                                valid;
    logic                                ready;
    logic signed [sbbc_pkg::SAMPLE_W-1:0] sample_out;
    logic                                channel_out;

    modport source (output valid, output sample_out, output channel_out, input ready);
    modport sink   (input valid, input sample_out, input channel_out, output ready);
endinterface

interface sbbc_cfg_if;
    logic                                 valid;
    logic                                 ready;
    logic [sbbc_pkg::CFG_IDX_W-1:0]       index;
    logic [sbbc_pkg::COEF_W-1:0]          data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

>>> sv/sbbc_ctrl.sv
// sbbc_ctrl: sequencer for the biquad cascade, one section at a time
// depends on sbbc_pkg (t_cmd, t_stat, term codes)
module sbbc_ctrl #(
    parameter int STAGES = 10
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  sbbc_pkg::t_stat              i_stat,
    output sbbc_pkg::t_cmd               o_cmd,
    output logic [$clog2(2*STAGES)-1:0]  o_sect
);

    localparam int SECTS  = 2 * STAGES;
    localparam int SECT_W = $clog2(SECTS);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RD   = 3'd1;
    localparam logic [2:0] S_MAC  = 3'd2;
    localparam logic [2:0] S_WB   = 3'd3;
    localparam logic [2:0] S_CONV = 3'd4;
    localparam logic [2:0] S_OUT  = 3'd5;

    localparam logic [SECT_W-1:0] SECT_LAST = SECT_W'(SECTS - 1);
    localparam logic [SECT_W-1:0] SECT_LP   = SECT_W'(STAGES);

    logic [2:0]                  r_state, n_state;
    logic [SECT_W-1:0]           r_sect, n_sect;
    logic [sbbc_pkg::TERM_W-1:0] r_k, n_k;
    logic                        w_last;

    assign w_last     = (r_sect == SECT_LAST);
    assign o_in_ready = (r_state == S_IDLE);
    assign o_sect     = r_sect;

    always_comb begin
        o_cmd          = '0;
        o_cmd.start    = (r_state == S_IDLE) && i_in_valid;
        o_cmd.rd       = (r_state == S_RD);
        o_cmd.mul      = (r_state == S_MAC) && (r_k != sbbc_pkg::TERM_NONE);
        o_cmd.term     = r_k;
        o_cmd.acc      = (r_state == S_MAC) && (r_k != sbbc_pkg::TERM_X);
        o_cmd.wb       = (r_state == S_WB);
        o_cmd.is_lp    = (r_sect >= SECT_LP);
        o_cmd.conv     = (r_state == S_CONV);
        o_cmd.load_out = (r_state == S_OUT) && i_stat.out_free;
    end

    always_comb begin
        n_state = r_state;
        n_sect  = r_sect;
        n_k     = r_k;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_RD;
                    n_sect  = '0;
                end
            end
            S_RD: begin
                n_state = S_MAC;
                n_k     = sbbc_pkg::TERM_X;
            end
            S_MAC: begin
                if (r_k == sbbc_pkg::TERM_NONE) begin
                    n_state = S_WB;
                end else begin
                    n_k = r_k + 1'b1;
                end
            end
            S_WB: begin
                if (w_last) begin
                    n_state = S_CONV;
                end else begin
                    n_state = S_RD;
                    n_sect  = r_sect + 1'b1;
                end
            end
            S_CONV: begin
                n_state = S_OUT;
            end
            S_OUT: begin
                if (i_stat.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_sect  <= '0;
            r_k     <= sbbc_pkg::TERM_X;
        end else begin
            r_state <= n_state;
            r_sect  <= n_sect;
            r_k     <= n_k;
        end
    end

    a_start_reads_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.start |=> (r_state == S_RD) && (r_sect == '0))
        else $error("accepted sample did not start at the first section");

    a_last_wb_converts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WB) && w_last |=> (r_state == S_CONV))
        else $error("last section not followed by conversion");

    a_mac_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MAC) |-> (r_k <= sbbc_pkg::TERM_NONE))
        else $error("term counter out of range");

endmodule

>>> sv/sbbc_dp.sv
// sbbc_dp: coefficient registers, history memory, shared multiply-accumulate,
// output conversion and output register; depends on sbbc_pkg
module sbbc_dp #(
    parameter int STAGES       = 10,
    parameter int MAX_CHANNELS = 2
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  sbbc_pkg::t_cmd                        i_cmd,
    input  logic [$clog2(2*STAGES)-1:0]           i_sect,
    output sbbc_pkg::t_stat                       o_stat,
    input  logic signed [sbbc_pkg::SAMPLE_W-1:0]  i_sample,
    input  logic                                  i_clear,
    input  logic                                  i_cfg_we,
    input  logic [sbbc_pkg::CFG_IDX_W-1:0]        i_cfg_idx,
    input  logic [sbbc_pkg::COEF_W-1:0]           i_cfg_data,
    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output logic signed [sbbc_pkg::SAMPLE_W-1:0]  o_sample,
    output logic                                  o_channel
);

    localparam int CW     = sbbc_pkg::COEF_W;
    localparam int SECTS  = 2 * STAGES;
    localparam int ROWS   = MAX_CHANNELS * SECTS;
    localparam int ROW_W  = $clog2(ROWS);
    localparam int CH_W   = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int RB     = sbbc_pkg::ROW_BITS;
    localparam int PROD_W = 2 * CW;
    localparam int ACC_W  = PROD_W + 3;
    localparam int QF     = sbbc_pkg::Q_FRAC;
    localparam int MAG_W  = QF;
    localparam int CP_W   = MAG_W + 15;

    localparam logic [1:0] OP_ADD  = 2'd0;
    localparam logic [1:0] OP_ADD2 = 2'd1;
    localparam logic [1:0] OP_SUB2 = 2'd2;
    localparam logic [1:0] OP_SUB  = 2'd3;

    localparam logic signed [CW-1:0] CLAMP_POS = {{(CW-QF){1'b0}}, sbbc_pkg::CLAMP_Q};
    localparam logic signed [CW-1:0] CLAMP_NEG = -CLAMP_POS;
    localparam logic [3:0]           NCH_MAX   = 4'(MAX_CHANNELS);

    // configuration
    logic signed [CW-1:0]           r_hp_b0, r_hp_a1, r_hp_a2;
    logic signed [CW-1:0]           r_lp_b0, r_lp_a1, r_lp_a2;
    logic [sbbc_pkg::NCH_W-1:0]     r_nch;
    logic [3:0]                     w_nch_eff;

    // channel tracking
    logic [CH_W-1:0]                r_chan, r_ch;
    logic [CH_W-1:0]                w_ch_cur, w_ch_nxt;

    // history memory, one row per section per channel
    logic [RB-1:0]                  mem [ROWS];
    logic [ROWS-1:0]                r_valid;
    logic [RB-1:0]                  r_row;
    logic                           r_row_vld;
    logic [ROW_W-1:0]               w_addr;
    logic signed [CW-1:0]           w_x1, w_x2, w_y1, w_y2;

    // multiply-accumulate
    logic signed [CW-1:0]           r_v;
    logic signed [CW-1:0]           w_b0, w_a1, w_a2, w_ma, w_mb;
    logic [1:0]                     w_op, r_op;
    logic signed [PROD_W-1:0]       w_prod, r_prod;
    logic signed [ACC_W-1:0]        r_acc, w_pext, n_acc, w_shift;
    logic signed [CW-1:0]           w_y;
    logic [RB-1:0]                  w_row_new;

    // output conversion
    logic signed [CW-1:0]           w_vc;
    logic [MAG_W-1:0]               w_mag;
    logic [CP_W-1:0]                r_cprod;
    logic                           r_neg;
    logic [14:0]                    w_mout;
    logic                           r_out_vld;
    logic signed [sbbc_pkg::SAMPLE_W-1:0] r_out_smp;
    logic                           r_out_ch;

    // effective channel count and channel of the new sample
    always_comb begin
        if (r_nch == '0) begin
            w_nch_eff = 4'd1;
        end else if (4'(r_nch) > NCH_MAX) begin
            w_nch_eff = NCH_MAX;
        end else begin
            w_nch_eff = 4'(r_nch);
        end
        if (i_clear || (4'(r_chan) >= w_nch_eff)) begin
            w_ch_cur = '0;
        end else begin
            w_ch_cur = r_chan;
        end
        if ((4'(w_ch_cur) + 4'd1) >= w_nch_eff) begin
            w_ch_nxt = '0;
        end else begin
            w_ch_nxt = w_ch_cur + 1'b1;
        end
    end

    assign w_addr = ROW_W'(ROW_W'(r_ch) * ROW_W'(SECTS)) + ROW_W'(i_sect);

    assign w_x1 = r_row_vld ? r_row[4*CW-1:3*CW] : '0;
    assign w_x2 = r_row_vld ? r_row[3*CW-1:2*CW] : '0;
    assign w_y1 = r_row_vld ? r_row[2*CW-1:CW]   : '0;
    assign w_y2 = r_row_vld ? r_row[CW-1:0]      : '0;

    assign w_b0 = i_cmd.is_lp ? r_lp_b0 : r_hp_b0;
    assign w_a1 = i_cmd.is_lp ? r_lp_a1 : r_hp_a1;
    assign w_a2 = i_cmd.is_lp ? r_lp_a2 : r_hp_a2;

    always_comb begin
        unique case (i_cmd.term)
            sbbc_pkg::TERM_X: begin
                w_ma = w_b0;
                w_mb = r_v;
                w_op = OP_ADD;
            end
            sbbc_pkg::TERM_X1: begin
                w_ma = w_b0;
                w_mb = w_x1;
                w_op = i_cmd.is_lp ? OP_ADD2 : OP_SUB2;
            end
            sbbc_pkg::TERM_X2: begin
                w_ma = w_b0;
                w_mb = w_x2;
                w_op = OP_ADD;
            end
            sbbc_pkg::TERM_Y1: begin
                w_ma = w_a1;
                w_mb = w_y1;
                w_op = OP_SUB;
            end
            sbbc_pkg::TERM_Y2: begin
                w_ma = w_a2;
                w_mb = w_y2;
                w_op = OP_SUB;
            end
            default: begin
                w_ma = '0;
                w_mb = '0;
                w_op = OP_ADD;
            end
        endcase
    end

    assign w_prod = w_ma * w_mb;
    assign w_pext = {{(ACC_W-PROD_W){r_prod[PROD_W-1]}}, r_prod};

    always_comb begin
        unique case (r_op)
            OP_ADD:  n_acc = r_acc + w_pext;
            OP_ADD2: n_acc = r_acc + (w_pext <<< 1);
            OP_SUB2: n_acc = r_acc - (w_pext <<< 1);
            OP_SUB:  n_acc = r_acc - w_pext;
            default: n_acc = r_acc;
        endcase
    end

    // floor shift and saturation to q4.28
    always_comb begin
        w_shift = r_acc >>> QF;
        if (w_shift[ACC_W-1:CW-1] == '0 || w_shift[ACC_W-1:CW-1] == '1) begin
            w_y = w_shift[CW-1:0];
        end else if (w_shift[ACC_W-1]) begin
            w_y = {1'b1, {(CW-1){1'b0}}};
        end else begin
            w_y = {1'b0, {(CW-1){1'b1}}};
        end
    end

    assign w_row_new = {r_v, w_x1, w_y, w_y1};

    // clamp and magnitude for the output scaling
    always_comb begin
        if (r_v > CLAMP_POS) begin
            w_vc = CLAMP_POS;
        end else if (r_v < CLAMP_NEG) begin
            w_vc = CLAMP_NEG;
        end else begin
            w_vc = r_v;
        end
        w_mag = w_vc[CW-1] ? MAG_W'(-w_vc) : w_vc[MAG_W-1:0];
    end

    assign w_mout = r_cprod[CP_W-1:QF];

    assign o_stat.out_free = !r_out_vld || i_out_ready;
    assign o_out_valid     = r_out_vld;
    assign o_sample        = r_out_smp;
    assign o_channel       = r_out_ch;

    always_ff @(posedge i_clk) begin
        if (i_cmd.wb) begin
            mem[w_addr] <= w_row_new;
        end
        if (i_cmd.rd) begin
            r_row <= mem[w_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hp_b0   <= '0;
            r_hp_a1   <= '0;
            r_hp_a2   <= '0;
            r_lp_b0   <= '0;
            r_lp_a1   <= '0;
            r_lp_a2   <= '0;
            r_nch     <= 2'd1;
            r_chan    <= '0;
            r_ch      <= '0;
            r_valid   <= '0;
            r_out_vld <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    sbbc_pkg::CFG_HP_B0:  r_hp_b0 <= i_cfg_data;
                    sbbc_pkg::CFG_HP_A1:  r_hp_a1 <= i_cfg_data;
                    sbbc_pkg::CFG_HP_A2:  r_hp_a2 <= i_cfg_data;
                    sbbc_pkg::CFG_LP_B0:  r_lp_b0 <= i_cfg_data;
                    sbbc_pkg::CFG_LP_A1:  r_lp_a1 <= i_cfg_data;
                    sbbc_pkg::CFG_LP_A2:  r_lp_a2 <= i_cfg_data;
                    sbbc_pkg::CFG_NUM_CH: r_nch   <= i_cfg_data[sbbc_pkg::NCH_W-1:0];
                    default: ;
                endcase
            end
            if (i_cmd.start) begin
                r_ch   <= w_ch_cur;
                r_chan <= w_ch_nxt;
                if (i_clear) begin
                    r_valid <= '0;
                end
            end
            if (i_cmd.wb) begin
                r_valid[w_addr] <= 1'b1;
            end
            if (i_cmd.load_out) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_v <= {{(CW-sbbc_pkg::SAMPLE_W-sbbc_pkg::IN_SHIFT){i_sample[sbbc_pkg::SAMPLE_W-1]}},
                    i_sample, {sbbc_pkg::IN_SHIFT{1'b0}}};
        end else if (i_cmd.wb) begin
            r_v <= w_y;
        end
        if (i_cmd.rd) begin
            r_row_vld <= r_valid[w_addr];
            r_acc     <= '0;
        end else if (i_cmd.acc) begin
            r_acc <= n_acc;
        end
        if (i_cmd.mul) begin
            r_prod <= w_prod;
            r_op   <= w_op;
        end
        if (i_cmd.conv) begin
            r_cprod <= CP_W'(w_mag) * CP_W'(sbbc_pkg::OUT_SCALE);
            r_neg   <= r_v[CW-1];
        end
        if (i_cmd.load_out) begin
            r_out_smp <= r_neg ? -{1'b0, w_mout} : {1'b0, w_mout};
            r_out_ch  <= r_ch[0];
        end
    end

    a_wb_marks_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.wb |=> r_valid[$past(w_addr)])
        else $error("written history row not marked valid");

    a_clear_drops_rows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.start && i_clear |=> (r_valid == '0) && (r_ch == '0))
        else $error("clear did not drop histories");

    a_channel_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.start |=> (4'(r_ch) < $past(w_nch_eff)))
        else $error("active channel beyond channel count");

endmodule

>>> sv/speech_band_biquad_cascade_top.sv
// speech_band_biquad_cascade_top: 2*STAGES biquad sections over interleaved channels
// depends on sbbc_pkg, sbbc_ifs, sbbc_ctrl and sbbc_dp
//
//   channel  dir  beat carries
//   i_in     in   sample_in[15:0] signed, clear_history
//   o_out    out  sample_out[15:0] signed, channel_out
//   i_cfg    in   index[2:0], data[31:0] (always ready)
//
// a sample is accepted only in idle; its sections run one after another and the result is
// loaded into the output register before the next sample is taken; the sections share
// one 32x32 multiplier doing five products per section, with one history row read and
// written per section
// synchronous reset clears all histories at once through per-row valid bits
// a finished result waits in the output register while the next sample is taken;
// the next result holds in the sequencer until that register frees
module speech_band_biquad_cascade_top #(
    parameter int STAGES       = 10,
    parameter int MAX_CHANNELS = 2
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    sbbc_in_if.sink      i_in,
    sbbc_out_if.source   o_out,
    sbbc_cfg_if.sink     i_cfg
);

    localparam int SECT_W = $clog2(2 * STAGES);

    sbbc_pkg::t_cmd      w_cmd;
    sbbc_pkg::t_stat     w_stat;
    logic [SECT_W-1:0]   w_sect;
    logic                w_in_ready;

    assign i_in.ready  = w_in_ready;
    assign i_cfg.ready = 1'b1;

    sbbc_ctrl #(
        .STAGES (STAGES)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (w_in_ready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd),
        .o_sect     (w_sect)
    );

    sbbc_dp #(
        .STAGES       (STAGES),
        .MAX_CHANNELS (MAX_CHANNELS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_sect      (w_sect),
        .o_stat      (w_stat),
        .i_sample    (i_in.sample_in),
        .i_clear     (i_in.clear_history),
        .i_cfg_we    (i_cfg.valid),
        .i_cfg_idx   (i_cfg.index),
        .i_cfg_data  (i_cfg.data),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .o_sample    (o_out.sample_out),
        .o_channel   (o_out.channel_out)
    );

endmodule
